// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the sine cone surface rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check masked while rst is high, through disable iff
`define SCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define SCE_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sce_pkg.sv =====
// shared types, constants and rounding helpers for the sine cone surface evaluator
// no dependencies; used by sce_trig and sine_cone_surface_eval
package sce_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 16;

   localparam int TRIG_STAGES = 6;
   localparam int LAST_STAGE  = 12;

   // csr register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_K_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_N_FREQ = 1'd1;

   localparam logic signed [15:0] K_GAIN_RESET = 16'sd384;
   localparam logic signed [15:0] N_FREQ_RESET = 16'sd128;

   // quarter sine polynomial, q30
   localparam logic [31:0] POLY_A  = 32'd1686629713;
   localparam logic [31:0] POLY_B  = 32'd693598719;
   localparam logic [31:0] POLY_C  = 32'd85569278;
   localparam logic [31:0] POLY_D  = 32'd5026990;
   localparam logic [30:0] POLY_E  = 31'd172272;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] PHASE_MASK   = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

   localparam logic signed [31:0] UNIT_OUT = 32'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic signed [23:0] u_coord;
      logic signed [15:0] v_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
      logic signed [31:0] du_z;
      logic signed [31:0] dv_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] duv_z;
      logic signed [31:0] dvv_z;
   } rsp_type;

   // shift right rounding half away from zero
   function automatic logic signed [95:0] round_shift(input logic signed [95:0] val,
                                                      input int unsigned sh);
      logic [95:0] mag;
      logic [95:0] half;
      logic [95:0] q;
      mag  = val[95] ? 96'(-val) : 96'(val);
      half = (96'd1 << sh) >> 1;
      q    = (mag + half) >> sh;
      return val[95] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [95:0] val);
      if (val > 96'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (val < -96'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return val[31:0];
      end
   endfunction

   function automatic logic signed [31:0] rsat(input logic signed [95:0] val,
                                               input int unsigned sh);
      return sat32(round_shift(val, sh));
   endfunction

endpackage

// ===== hw/rtl/sce_trig.sv =====
// six stage pipelined sine or cosine of a 32 bit turn fraction, q24 result
// depends on sce_pkg
module sce_trig (
   input  logic                clock,
   input  logic [6:1]          en,
   input  logic                cos_sel,
   input  logic [31:0]         phase,
   output logic signed [25:0]  value
);

   logic [31:0] p;
   logic [30:0] f0;
   logic [61:0] sq;
   logic [30:0] f_ff   [1:5];
   logic [30:0] f_in   [1:5];
   logic        neg_ff [1:5];
   logic        neg_in [1:5];
   logic [30:0] x2_ff  [1:4];
   logic [30:0] x2_in  [1:4];
   logic [30:0] r_ff   [2:5];
   logic [30:0] r_in   [2:5];
   logic [31:0] coef   [2:5];
   logic [30:0] r_prev [2:5];
   logic [61:0] m      [2:5];
   logic [61:0] m6;
   logic [31:0] s6;
   logic [31:0] sc6;
   logic [24:0] rr6;
   logic signed [25:0] value_ff;
   logic signed [25:0] value_in;

   always_comb begin
      p  = (phase & sce_pkg::PHASE_MASK) + (cos_sel ? sce_pkg::QUARTER_TURN : 32'd0);
      f0 = p[30] ? (sce_pkg::ONE_Q30 - {1'b0, p[29:0]}) : {1'b0, p[29:0]};
      sq = f0 * f0;
      f_in[1]   = f0;
      neg_in[1] = p[31];
      x2_in[1]  = sq[60:30];
      for (int s = 2; s <= 5; s++) begin
         f_in[s]   = f_ff[s-1];
         neg_in[s] = neg_ff[s-1];
      end
      for (int s = 2; s <= 4; s++) begin
         x2_in[s] = x2_ff[s-1];
      end
      coef[2] = sce_pkg::POLY_D;
      coef[3] = sce_pkg::POLY_C;
      coef[4] = sce_pkg::POLY_B;
      coef[5] = sce_pkg::POLY_A;
      r_prev[2] = sce_pkg::POLY_E;
      for (int s = 3; s <= 5; s++) begin
         r_prev[s] = r_ff[s-1];
      end
      // horner steps, one per stage
      for (int s = 2; s <= 5; s++) begin
         m[s]    = x2_ff[s-1] * r_prev[s];
         r_in[s] = 31'(coef[s] - m[s][61:30]);
      end
      m6  = f_ff[5] * r_ff[5];
      s6  = m6[61:30];
      sc6 = (s6 > 32'(sce_pkg::ONE_Q30)) ? 32'(sce_pkg::ONE_Q30) : s6;
      rr6 = 25'((sc6 + 32'd32) >> 6);
      value_in = neg_ff[5] ? -$signed({1'b0, rr6}) : $signed({1'b0, rr6});
   end

   always_ff @(posedge clock) begin
      for (int s = 1; s <= 5; s++) begin
         if (en[s]) begin
            f_ff[s]   <= f_in[s];
            neg_ff[s] <= neg_in[s];
         end
      end
      for (int s = 1; s <= 4; s++) begin
         if (en[s]) begin
            x2_ff[s] <= x2_in[s];
         end
      end
      for (int s = 2; s <= 5; s++) begin
         if (en[s]) begin
            r_ff[s] <= r_in[s];
         end
      end
      if (en[6]) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/sine_cone_surface_eval.sv =====
// sine cone surface evaluator top level: point, derivatives and normal per (u, v)
// depends on sce_pkg, sce_trig and assert_macros.svh
//
// usage
//  - req channel: valid/ready, payload u_coord (q8.16) and v_angle (binary angle)
//  - rsp channel: valid/ready, eleven q16.16 saturated fields per request
//  - csr port: csr_we with csr_index/csr_wdata writes k_gain (0) or n_freq (1);
//    write only while no request is in flight
//  - thirteen register stages, at most one multiply level each; a request
//    moves through stages 0 to 12 in order and shows on rsp from stage 12; the
//    trig polynomial depth and the wide product splits set the stage count
//  - throughput one request per cycle while rsp is not stalled: every stage can
//    move each cycle and ready runs back through the whole chain in the same cycle
//  - four trig pipelines run in parallel: cos v, sin v, cos nv, sin nv
//  - every stage has its own valid bit; ready ripples back so bubbles
//    are squeezed out and a stalled rsp only holds the stages behind it
//  - reset clears all valid bits and loads k = 1.5, n = 0.5
`include "assert_macros.svh"

module sine_cone_surface_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sce_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sce_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [sce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [15:0]                         csr_wdata
);

   typedef struct packed {
      logic signed [23:0] u;
      logic signed [39:0] ku;
      logic signed [31:0] kn;
      logic signed [55:0] knu;
      logic signed [46:0] knn;
   } carry_type;

   localparam int LS = sce_pkg::LAST_STAGE;
   localparam int FB = sce_pkg::FRAC_BITS;

   // config registers
   logic signed [15:0] k_ff;
   logic signed [15:0] n_ff;

   // stage valid bits and ready chain
   logic [LS:0] v_ff;
   logic [LS:0] v_in;
   logic [LS:0] rdy;

   // stage 0
   logic signed [23:0] u0_ff;
   logic [31:0]        phv0_ff;
   logic [31:0]        phnv0_ff;
   logic signed [39:0] ku0_ff;
   logic signed [31:0] kn0_ff;
   logic signed [31:0] nv;

   // stages 1..6 side band
   carry_type carry_ff [1:6];
   carry_type carry_in [1:6];

   // trig results at stage 6
   logic signed [25:0] cv6;
   logic signed [25:0] sv6;
   logic signed [25:0] cn6;
   logic signed [25:0] sn6;

   // stage 7
   logic signed [49:0] px7_ff,   px7_in;
   logic signed [49:0] py7_ff,   py7_in;
   logic signed [65:0] pz7_ff,   pz7_in;
   logic signed [41:0] dz7_ff,   dz7_in;
   logic signed [25:0] cv7_ff;
   logic signed [25:0] sv7_ff;
   logic signed [25:0] sn7_ff;
   logic signed [54:0] dvzl7_ff, dvzl7_in;
   logic signed [53:0] dvzh7_ff, dvzh7_in;
   logic signed [41:0] nsv7_ff,  nsv7_in;
   logic signed [41:0] ncv7_ff,  ncv7_in;
   logic signed [51:0] cc7_ff,   cc7_in;
   logic signed [51:0] sc7_ff,   sc7_in;
   logic signed [57:0] duv7_ff,  duv7_in;
   logic signed [50:0] knnl7_ff, knnl7_in;
   logic signed [48:0] knnh7_ff, knnh7_in;
   logic signed [23:0] u7_ff;
   logic signed [39:0] ku7_ff;

   // stage 8
   sce_pkg::rsp_type   rsp8_ff,    rsp8_in;
   logic signed [83:0] dvz8_ff,    dvz8_in;
   logic signed [67:0] nsvsn8_ff,  nsvsn8_in;
   logic signed [67:0] ncvsn8_ff,  ncvsn8_in;
   logic signed [28:0] cc8_ff,     cc8_in;
   logic signed [28:0] sc8_ff,     sc8_in;
   logic signed [74:0] knncn8_ff,  knncn8_in;
   logic signed [23:0] u8_ff;
   logic signed [39:0] ku8_ff;

   // stage 9
   sce_pkg::rsp_type   rsp9_ff, rsp9_in;
   logic signed [33:0] dx9_ff,  dx9_in;
   logic signed [33:0] dy9_ff,  dy9_in;
   logic signed [47:0] t9_ff,   t9_in;
   logic signed [23:0] u9_ff;
   logic signed [39:0] ku9_ff;

   // stage 10
   sce_pkg::rsp_type   rsp10_ff;
   logic signed [57:0] nxl10_ff, nxl10_in;
   logic signed [56:0] nxh10_ff, nxh10_in;
   logic signed [57:0] nyl10_ff, nyl10_in;
   logic signed [56:0] nyh10_ff, nyh10_in;
   logic signed [71:0] dvv10_ff, dvv10_in;

   // stage 11
   sce_pkg::rsp_type   rsp11_ff, rsp11_in;
   logic signed [75:0] nx11_ff,  nx11_in;
   logic signed [75:0] ny11_ff,  ny11_in;

   // stage 12, the output register
   sce_pkg::rsp_type   rsp12_ff, rsp12_in;

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= sce_pkg::K_GAIN_RESET;
         n_ff <= sce_pkg::N_FREQ_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sce_pkg::CSR_K_GAIN: k_ff <= csr_wdata;
            sce_pkg::CSR_N_FREQ: n_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ready ripples back from the output register
   always_comb begin
      rdy[LS] = !v_ff[LS] || rsp_ready;
      for (int s = LS - 1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
      v_in[0] = req_valid;
      for (int s = 1; s <= LS; s++) begin
         v_in[s] = v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s <= LS; s++) begin
            if (rdy[s]) begin
               v_ff[s] <= v_in[s];
            end
         end
      end
   end

   assign req_ready = rdy[0];

   // stage 0: phases and first gain products
   assign nv = n_ff * req_payload.v_angle;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         u0_ff    <= req_payload.u_coord;
         phv0_ff  <= {req_payload.v_angle, 16'd0};
         phnv0_ff <= {nv[23:0], 8'd0};
         ku0_ff   <= k_ff * req_payload.u_coord;
         kn0_ff   <= k_ff * n_ff;
      end
   end

   // stages 1..6: carry the gain terms beside the trig pipelines
   always_comb begin
      carry_in[1].u   = u0_ff;
      carry_in[1].ku  = ku0_ff;
      carry_in[1].kn  = kn0_ff;
      carry_in[1].knu = kn0_ff * u0_ff;
      carry_in[1].knn = 47'(kn0_ff * n_ff);
      for (int s = 2; s <= 6; s++) begin
         carry_in[s] = carry_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 1; s <= 6; s++) begin
         if (rdy[s]) begin
            carry_ff[s] <= carry_in[s];
         end
      end
   end

   sce_trig u_trig_cv (.clock(clock), .en(rdy[6:1]), .cos_sel(1'b1), .phase(phv0_ff),
                       .value(cv6));
   sce_trig u_trig_sv (.clock(clock), .en(rdy[6:1]), .cos_sel(1'b0), .phase(phv0_ff),
                       .value(sv6));
   sce_trig u_trig_cn (.clock(clock), .en(rdy[6:1]), .cos_sel(1'b1), .phase(phnv0_ff),
                       .value(cn6));
   sce_trig u_trig_sn (.clock(clock), .en(rdy[6:1]), .cos_sel(1'b0), .phase(phnv0_ff),
                       .value(sn6));

   // stage 7: first products of trig values; wide ones split into halves
   always_comb begin
      px7_in   = carry_ff[6].u * cv6;
      py7_in   = carry_ff[6].u * sv6;
      pz7_in   = carry_ff[6].ku * cn6;
      dz7_in   = k_ff * cn6;
      dvzl7_in = $signed({1'b0, carry_ff[6].knu[27:0]}) * sn6;
      dvzh7_in = $signed(carry_ff[6].knu[55:28]) * sn6;
      nsv7_in  = n_ff * sv6;
      ncv7_in  = n_ff * cv6;
      cc7_in   = cv6 * cn6;
      sc7_in   = sv6 * cn6;
      duv7_in  = carry_ff[6].kn * sn6;
      knnl7_in = $signed({1'b0, carry_ff[6].knn[23:0]}) * cn6;
      knnh7_in = $signed(carry_ff[6].knn[46:24]) * cn6;
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         px7_ff   <= px7_in;
         py7_ff   <= py7_in;
         pz7_ff   <= pz7_in;
         dz7_ff   <= dz7_in;
         cv7_ff   <= cv6;
         sv7_ff   <= sv6;
         sn7_ff   <= sn6;
         dvzl7_ff <= dvzl7_in;
         dvzh7_ff <= dvzh7_in;
         nsv7_ff  <= nsv7_in;
         ncv7_ff  <= ncv7_in;
         cc7_ff   <= cc7_in;
         sc7_ff   <= sc7_in;
         duv7_ff  <= duv7_in;
         knnl7_ff <= knnl7_in;
         knnh7_ff <= knnh7_in;
         u7_ff    <= carry_ff[6].u;
         ku7_ff   <= carry_ff[6].ku;
      end
   end

   // stage 8: finish the simple fields, merge split halves
   always_comb begin
      rsp8_in          = '0;
      rsp8_in.pos_x    = sce_pkg::rsat(96'(px7_ff), 40 - FB);
      rsp8_in.pos_y    = sce_pkg::rsat(96'(py7_ff), 40 - FB);
      rsp8_in.pos_z    = sce_pkg::rsat(96'(pz7_ff), 48 - FB);
      rsp8_in.cos_v    = sce_pkg::rsat(96'(cv7_ff), 24 - FB);
      rsp8_in.sin_v    = sce_pkg::rsat(96'(sv7_ff), 24 - FB);
      rsp8_in.du_z     = sce_pkg::rsat(96'(dz7_ff), 32 - FB);
      rsp8_in.duv_z    = sce_pkg::rsat(-96'(duv7_ff), 40 - FB);
      dvz8_in   = -((84'(dvzh7_ff) <<< 28) + 84'(dvzl7_ff));
      nsvsn8_in = nsv7_ff * sn7_ff;
      ncvsn8_in = ncv7_ff * sn7_ff;
      cc8_in    = 29'(sce_pkg::round_shift(96'(cc7_ff), 24));
      sc8_in    = 29'(sce_pkg::round_shift(96'(sc7_ff), 24));
      knncn8_in = (75'(knnh7_ff) <<< 24) + 75'(knnl7_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         rsp8_ff   <= rsp8_in;
         dvz8_ff   <= dvz8_in;
         nsvsn8_ff <= nsvsn8_in;
         ncvsn8_ff <= ncvsn8_in;
         cc8_ff    <= cc8_in;
         sc8_ff    <= sc8_in;
         knncn8_ff <= knncn8_in;
         u8_ff     <= u7_ff;
         ku8_ff    <= ku7_ff;
      end
   end

   // stage 9: normal brackets and the q24 k n n cos nv term
   always_comb begin
      rsp9_in      = rsp8_ff;
      rsp9_in.dv_z = sce_pkg::rsat(96'(dvz8_ff), 56 - FB);
      dx9_in = 34'(sce_pkg::round_shift(96'(nsvsn8_ff), 32)) - 34'(cc8_ff);
      dy9_in = 34'(sce_pkg::round_shift(96'(ncvsn8_ff), 32)) - 34'(sc8_ff);
      t9_in  = 48'(sce_pkg::round_shift(96'(knncn8_ff), 24));
   end

   always_ff @(posedge clock) begin
      if (rdy[9]) begin
         rsp9_ff <= rsp9_in;
         dx9_ff  <= dx9_in;
         dy9_ff  <= dy9_in;
         t9_ff   <= t9_in;
         u9_ff   <= u8_ff;
         ku9_ff  <= ku8_ff;
      end
   end

   // stage 10: k u times brackets, split on the bracket
   always_comb begin
      nxl10_in = ku9_ff * $signed({1'b0, dx9_ff[16:0]});
      nxh10_in = ku9_ff * $signed(dx9_ff[33:17]);
      nyl10_in = ku9_ff * $signed({1'b0, dy9_ff[16:0]});
      nyh10_in = ku9_ff * $signed(dy9_ff[33:17]);
      dvv10_in = t9_ff * u9_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[10]) begin
         rsp10_ff <= rsp9_ff;
         nxl10_ff <= nxl10_in;
         nxh10_ff <= nxh10_in;
         nyl10_ff <= nyl10_in;
         nyh10_ff <= nyh10_in;
         dvv10_ff <= dvv10_in;
      end
   end

   // stage 11: merge normal halves, finish dvv_z
   always_comb begin
      rsp11_in       = rsp10_ff;
      rsp11_in.dvv_z = sce_pkg::rsat(-96'(dvv10_ff), 40 - FB);
      nx11_in = -((76'(nxh10_ff) <<< 17) + 76'(nxl10_ff));
      ny11_in = (76'(nyh10_ff) <<< 17) + 76'(nyl10_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[11]) begin
         rsp11_ff <= rsp11_in;
         nx11_ff  <= nx11_in;
         ny11_ff  <= ny11_in;
      end
   end

   // stage 12: round the normal into the output register
   always_comb begin
      rsp12_in          = rsp11_ff;
      rsp12_in.normal_x = sce_pkg::rsat(96'(nx11_ff), 48 - FB);
      rsp12_in.normal_y = sce_pkg::rsat(96'(ny11_ff), 48 - FB);
   end

   always_ff @(posedge clock) begin
      if (rdy[LS]) begin
         rsp12_ff <= rsp12_in;
      end
   end

   assign rsp_valid   = v_ff[LS];
   assign rsp_payload = rsp12_ff;

   // an open output register means the whole chain can take a request
   `SCE_ASSERT(a_ready_chain, clock, reset, rsp_ready |-> req_ready, "req_ready low with rsp_ready high")
   // nothing leaves the block right after reset
   `SCE_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid after reset")
   // cosine of v never exceeds one
   `SCE_ASSERT(a_cos_range, clock, reset, rsp_valid |-> ((rsp_payload.cos_v <= sce_pkg::UNIT_OUT) && (rsp_payload.cos_v >= -sce_pkg::UNIT_OUT)), "cos_v out of range")

endmodule
